FILE: rtl/clnw_pkg.sv
// Shared types, constants and the init command table for the LCD nibble writer.
`timescale 1ns / 1ps
`default_nettype none

package clnw_pkg;

  localparam int unsigned MAX_DIGITS = 5;
  localparam int unsigned DCNT_W     = $clog2(MAX_DIGITS + 1);
  localparam int unsigned VALUE_W    = 15;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned NIBBLE_W   = 4;

  localparam logic [7:0] HIGH_NIBBLE_MASK = 8'hF0;
  localparam logic [7:0] CMD_ENTRY_LEFT   = 8'h04;
  localparam logic [7:0] CMD_ENTRY_RIGHT  = 8'h06;
  localparam logic [7:0] ASCII_ZERO       = 8'd48;
  localparam logic [7:0] CMD_HOME         = 8'h02;
  localparam logic [7:0] CMD_FUNC_4BIT    = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;

  // floor(v / 10) == (v * 52429) >> 19 for every 15-bit v
  localparam logic [15:0] DIV10_RECIP = 16'd52429;
  localparam int unsigned DIV10_SHIFT = 19;

  typedef enum logic [OP_W-1:0] {
    OP_CMD  = 2'd0,
    OP_DATA = 2'd1,
    OP_NUM  = 2'd2,
    OP_INIT = 2'd3
  } clnw_op_e;

  typedef enum logic [2:0] {
    SRC_VALUE,
    SRC_ENTRY_LEFT,
    SRC_DIGIT,
    SRC_ENTRY_RIGHT,
    SRC_INIT
  } clnw_src_e;

  typedef struct packed {
    logic      load_value;
    logic      load_byte;
    clnw_src_e src;
    logic [1:0] init_idx;
    logic      emit;
    logic      emit_hi;
    logic      emit_rs;
    logic      emit_last;
  } clnw_cmd_t;

  typedef struct packed {
    logic out_free;
    logic value_zero;
  } clnw_status_t;

  function automatic logic [7:0] init_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0: b = CMD_HOME;
      2'd1: b = CMD_FUNC_4BIT;
      2'd2: b = CMD_ENTRY_RIGHT;
      2'd3: b = CMD_DISPLAY_ON;
      default: b = CMD_HOME;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/clnw_ctrl.sv
// Sequencer that walks each item through its bytes and nibble strobes.
`timescale 1ns / 1ps
`default_nettype none

module clnw_ctrl
  import clnw_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [OP_W-1:0]      op_i,
  input  wire clnw_status_t         status_i,
  output clnw_cmd_t                 cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_BYTE = 4'b0010,
    ST_HI   = 4'b0100,
    ST_LO   = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  clnw_op_e          op_q, op_d;
  logic              rs_q, rs_d;
  logic              last_q, last_d;
  logic [1:0]        init_idx_q, init_idx_d;
  logic [DCNT_W-1:0] dcnt_q, dcnt_d;
  logic              entry_done_q, entry_done_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    rs_d         = rs_q;
    last_d       = last_q;
    init_idx_d   = init_idx_q;
    dcnt_d       = dcnt_q;
    entry_done_d = entry_done_q;

    cmd_o.load_value = 1'b0;
    cmd_o.load_byte  = 1'b0;
    cmd_o.src        = SRC_VALUE;
    cmd_o.init_idx   = init_idx_q;
    cmd_o.emit       = 1'b0;
    cmd_o.emit_hi    = 1'b0;
    cmd_o.emit_rs    = rs_q;
    cmd_o.emit_last  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_value = 1'b1;
          op_d             = clnw_op_e'(op_i);
          init_idx_d       = 2'd0;
          dcnt_d           = '0;
          entry_done_d     = 1'b0;
          state_d          = ST_BYTE;
        end
      end
      ST_BYTE: begin
        cmd_o.load_byte = 1'b1;
        state_d         = ST_HI;
        unique case (op_q)
          OP_CMD: begin
            cmd_o.src = SRC_VALUE;
            rs_d      = 1'b0;
            last_d    = 1'b1;
          end
          OP_DATA: begin
            cmd_o.src = SRC_VALUE;
            rs_d      = 1'b1;
            last_d    = 1'b1;
          end
          OP_NUM: begin
            if (!entry_done_q) begin
              cmd_o.src    = SRC_ENTRY_LEFT;
              rs_d         = 1'b0;
              last_d       = 1'b0;
              entry_done_d = 1'b1;
            end else if (status_i.value_zero || dcnt_q == DCNT_W'(MAX_DIGITS)) begin
              cmd_o.src = SRC_ENTRY_RIGHT;
              rs_d      = 1'b0;
              last_d    = 1'b1;
            end else begin
              cmd_o.src = SRC_DIGIT;
              rs_d      = 1'b1;
              last_d    = 1'b0;
              dcnt_d    = dcnt_q + DCNT_W'(1);
            end
          end
          OP_INIT: begin
            cmd_o.src  = SRC_INIT;
            rs_d       = 1'b0;
            last_d     = (init_idx_q == 2'd3);
            init_idx_d = init_idx_q + 2'd1;
          end
          default: begin
            cmd_o.src = SRC_VALUE;
          end
        endcase
      end
      ST_HI: begin
        if (status_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.emit_hi = 1'b1;
          state_d       = ST_LO;
        end
      end
      ST_LO: begin
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = last_q;
          state_d         = last_q ? ST_IDLE : ST_BYTE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      op_q         <= OP_CMD;
      rs_q         <= 1'b0;
      last_q       <= 1'b0;
      init_idx_q   <= 2'd0;
      dcnt_q       <= '0;
      entry_done_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      rs_q         <= rs_d;
      last_q       <= last_d;
      init_idx_q   <= init_idx_d;
      dcnt_q       <= dcnt_d;
      entry_done_q <= entry_done_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/clnw_dp.sv
// Value and byte registers, digit extraction and the output nibble register.
`timescale 1ns / 1ps
`default_nettype none

module clnw_dp
  import clnw_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [VALUE_W-1:0]  value_i,
  input  wire clnw_cmd_t           cmd_i,
  output clnw_status_t             status_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [NIBBLE_W-1:0]      nibble_o,
  output logic                     register_select_o,
  output logic                     last_nibble_o
);

  logic [VALUE_W-1:0]  value_q, value_d;
  logic [7:0]          byte_q, byte_d;
  logic                out_valid_q, out_valid_d;
  logic [NIBBLE_W-1:0] nibble_q, nibble_d;
  logic                rs_q, rs_d;
  logic                last_q, last_d;

  logic [30:0]         prod;
  logic [11:0]         quot;
  logic [VALUE_W-1:0]  quot_x10;
  logic [VALUE_W-1:0]  rem_full;
  logic [3:0]          digit;

  // divide by ten through the reciprocal, remainder by back-multiply
  assign prod     = 31'(value_q) * 31'(DIV10_RECIP);
  assign quot     = prod[30:DIV10_SHIFT];
  assign quot_x10 = {quot, 3'b000} + VALUE_W'({quot, 1'b0});
  assign rem_full = value_q - quot_x10;
  assign digit    = rem_full[3:0];

  assign status_o.out_free   = !out_valid_q || !out_stall_i;
  assign status_o.value_zero = (value_q == '0);

  always_comb begin
    value_d = value_q;
    byte_d  = byte_q;
    if (cmd_i.load_value) begin
      value_d = value_i;
    end
    if (cmd_i.load_byte) begin
      unique case (cmd_i.src)
        SRC_VALUE:       byte_d = value_q[7:0];
        SRC_ENTRY_LEFT:  byte_d = CMD_ENTRY_LEFT;
        SRC_DIGIT: begin
          byte_d  = ASCII_ZERO + {4'b0000, digit};
          value_d = VALUE_W'(quot);
        end
        SRC_ENTRY_RIGHT: byte_d = CMD_ENTRY_RIGHT;
        SRC_INIT:        byte_d = init_byte(cmd_i.init_idx);
        default:         byte_d = byte_q;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    nibble_d    = nibble_q;
    rs_d        = rs_q;
    last_d      = last_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      nibble_d    = cmd_i.emit_hi ? 4'((byte_q & HIGH_NIBBLE_MASK) >> 4) : byte_q[3:0];
      rs_d        = cmd_i.emit_rs;
      last_d      = cmd_i.emit_last;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    byte_q   <= byte_d;
    nibble_q <= nibble_d;
    rs_q     <= rs_d;
    last_q   <= last_d;
  end

  assign out_valid_o       = out_valid_q;
  assign nibble_o          = nibble_q;
  assign register_select_o = rs_q;
  assign last_nibble_o     = last_q;

endmodule

`default_nettype wire

FILE: rtl/char_lcd_nibble_writer.sv
// Top level of the 4-bit character LCD writer.
// One item is taken at a time: a command or data byte, a decimal number or the init
// sequence, sent as nibble beats (high nibble first) with register select and a last flag
// on the final beat. Every byte goes through byte select, then its high and low nibble pass
// through the output register, after a step that accepts the item; output stall holds them.
// A command or character is one byte, the init sequence four, and a number one byte per
// digit (up to five) between two entry-mode commands. Digits come from a reciprocal divide by ten.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_nibble_writer
  import clnw_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [OP_W-1:0]     op_i,
  input  wire logic [VALUE_W-1:0]  value_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [NIBBLE_W-1:0]      nibble_o,
  output logic                     register_select_o,
  output logic                     last_nibble_o
);

  clnw_cmd_t    cmd;
  clnw_status_t status;

  clnw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  clnw_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .value_i           (value_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .nibble_o          (nibble_o),
    .register_select_o (register_select_o),
    .last_nibble_o     (last_nibble_o)
  );

endmodule

`default_nettype wire

FILE: rtl/clnw_checker.sv
// Port-level checks for the LCD nibble writer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module clnw_checker
  import clnw_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire logic [NIBBLE_W-1:0] nibble_o,
  input wire logic                register_select_o,
  input wire logic                last_nibble_o
);

  logic       in_beat;
  logic       last_beat;
  logic [1:0] open_q, open_d;

  assign in_beat   = in_valid_i && !in_stall_o;
  assign last_beat = out_valid_o && !out_stall_i && last_nibble_o;

  // items accepted whose final beat has not yet been taken
  always_comb begin
    open_d = open_q;
    if (in_beat && !last_beat) begin
      open_d = open_q + 2'd1;
    end else if (!in_beat && last_beat) begin
      open_d = open_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 2'd0;
    end else begin
      open_q <= open_d;
    end
  end

  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> in_stall_o)
    else $error("input not stalled after accepting an item");

  a_no_orphan_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (open_q != 2'd0))
    else $error("output beat with no item in flight");

  a_open_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (open_q == 2'd2) |-> in_stall_o)
    else $error("new item taken while two are outstanding");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(nibble_o) && $stable(register_select_o)
       && $stable(last_nibble_o)))
    else $error("stalled output beat changed");

endmodule

bind char_lcd_nibble_writer clnw_checker u_clnw_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .nibble_o          (nibble_o),
  .register_select_o (register_select_o),
  .last_nibble_o     (last_nibble_o)
);

`default_nettype wire
